// ----- src/circular_address_generator_defines.svh -----
// ----------------------------------------------------------------------------
// Circular address generator assertion macros
// Concurrent check macros, clocked on clk and held off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef CIRCULAR_ADDRESS_GENERATOR_DEFINES_SVH
`define CIRCULAR_ADDRESS_GENERATOR_DEFINES_SVH

`ifndef SYNTH
// Consequent checked in the same cycle as the antecedent
`define CAG_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cag: same-cycle check failed");
// Consequent checked in the cycle after the antecedent
`define CAG_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cag: next-cycle check failed");
`else
`define CAG_ASSERT_SAME(label, ante, cons)
`define CAG_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ----- src/cag_pkg.sv -----
// ----------------------------------------------------------------------------
// Circular address generator package
// Field widths, operation codes and fixed constants shared by the RTL files.
// ----------------------------------------------------------------------------
package cag_pkg;

  localparam int ADDR_W     = 16;
  localparam int OP_W       = 3;
  localparam int REG_IDX_W  = 2;
  localparam int WRAP_REGS  = 4;
  localparam int CFG_IDX_W  = 2;

  // Carry-aware arithmetic width: one bit above the address
  localparam int EXT_W      = ADDR_W + 1;

  // Step limit that separates increasing from decreasing subtract steps
  localparam logic [EXT_W-1:0] NEG_LIMIT = EXT_W'(32'h0000_7FFF);

  localparam logic [ADDR_W-1:0] WRAP_RESET = '1;

  typedef enum logic [OP_W-1:0] {
    OP_INC  = 3'd0,
    OP_DEC  = 3'd1,
    OP_ADD  = 3'd2,
    OP_SUB  = 3'd3,
    OP_LOAD = 3'd4
  } op_t;

  typedef logic [ADDR_W-1:0] addr_t;

endpackage

// ----- src/cag_in_if.sv -----
// ----------------------------------------------------------------------------
// Circular address generator request channel
// Valid/ready channel carrying one address update request.
// ----------------------------------------------------------------------------
interface cag_in_if;
  logic                                valid;
  logic                                ready;
  logic [cag_pkg::OP_W-1:0]            operation;
  logic [cag_pkg::REG_IDX_W-1:0]       register_index;
  logic signed [cag_pkg::ADDR_W-1:0]   index_value;
  logic [cag_pkg::ADDR_W-1:0]          load_value;

  modport source(output valid, output operation, output register_index,
                 output index_value, output load_value, input ready);
  modport sink(input valid, input operation, input register_index,
               input index_value, input load_value, output ready);
endinterface

// ----- src/cag_out_if.sv -----
// ----------------------------------------------------------------------------
// Circular address generator result channel
// Valid/ready channel carrying one updated address.
// ----------------------------------------------------------------------------
interface cag_out_if;
  logic                          valid;
  logic                          ready;
  logic [cag_pkg::REG_IDX_W-1:0] result_register;
  logic [cag_pkg::ADDR_W-1:0]    new_address;

  modport source(output valid, output result_register, output new_address,
                 input ready);
  modport sink(input valid, input result_register, input new_address,
               output ready);
endinterface

// ----- src/circular_address_generator.sv -----
// Requests pass through a capture stage and a result stage. One transaction
// per cycle while the result side is ready; the address register read, the step
// unit and the register write-back complete as a request enters the result stage.
// Back-to-back updates of the same address register see the previous result.
// Reset (synchronous, rst_n low): address registers clear to zero, wrap sizes
// go to all ones, both pipeline stages empty.
// ----------------------------------------------------------------------------
// Circular address generator
// Modulo address unit with per-register wrap sizes and a write-only config port.
// ----------------------------------------------------------------------------
`include "circular_address_generator_defines.svh"

module circular_address_generator #(
  parameter int NUM_ADDR_REGS = 4
) (
  input  logic                             clk,
  input  logic                             rst_n,
  cag_in_if.sink                           in_ch,
  cag_out_if.source                        out_ch,
  input  logic                             cfg_we,
  input  logic [cag_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [cag_pkg::ADDR_W-1:0]       cfg_wdata
);

  // Capture stage
  logic                                s1_valid_r;
  logic [cag_pkg::OP_W-1:0]            s1_op_r;
  logic [cag_pkg::REG_IDX_W-1:0]       s1_idx_r;
  logic signed [cag_pkg::ADDR_W-1:0]   s1_ix_r;
  logic [cag_pkg::ADDR_W-1:0]          s1_ld_r;

  // Result stage
  logic                                out_valid_r;
  logic [cag_pkg::REG_IDX_W-1:0]       out_reg_r;
  cag_pkg::addr_t                      out_addr_r;

  cag_pkg::addr_t                      wrap_r [cag_pkg::WRAP_REGS];
  cag_pkg::addr_t                      addr_r [NUM_ADDR_REGS];

  logic                                advance;
  logic                                fire;
  logic                                idx_ok;
  logic                                load_fire;
  cag_pkg::addr_t                      cur_addr;
  cag_pkg::addr_t                      step_addr;
  cag_pkg::addr_t                      out_addr_nxt;

  assign advance      = !out_valid_r || out_ch.ready;
  assign fire         = s1_valid_r && advance;
  assign in_ch.ready  = !s1_valid_r || advance;
  assign idx_ok       = int'(s1_idx_r) < NUM_ADDR_REGS;
  assign load_fire    = fire && idx_ok && (s1_op_r == cag_pkg::OP_LOAD);

  always_comb begin
    cur_addr = '0;
    for (int i = 0; i < NUM_ADDR_REGS; i++) begin
      if (int'(s1_idx_r) == i) cur_addr = addr_r[i];
    end
  end

  cag_step u_step (
    .operation   (s1_op_r),
    .cur_addr    (cur_addr),
    .wrap_size   (wrap_r[s1_idx_r]),
    .index_value (s1_ix_r),
    .load_value  (s1_ld_r),
    .new_addr    (step_addr)
  );

  // Out-of-range register reads back as zero and updates nothing
  assign out_addr_nxt = idx_ok ? step_addr : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_op_r  <= in_ch.operation;
      s1_idx_r <= in_ch.register_index;
      s1_ix_r  <= in_ch.index_value;
      s1_ld_r  <= in_ch.load_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_reg_r  <= s1_idx_r;
      out_addr_r <= out_addr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_ADDR_REGS; i++) addr_r[i] <= '0;
    end else begin
      for (int i = 0; i < NUM_ADDR_REGS; i++) begin
        if (fire && int'(s1_idx_r) == i) addr_r[i] <= step_addr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < cag_pkg::WRAP_REGS; i++) wrap_r[i] <= cag_pkg::WRAP_RESET;
    end else if (cfg_we) begin
      wrap_r[cfg_index] <= cfg_wdata;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.result_register = out_reg_r;
  assign out_ch.new_address     = out_addr_r;

  `CAG_ASSERT_NEXT(a_s1_held, s1_valid_r && !advance, s1_valid_r)
  `CAG_ASSERT_NEXT(a_fire_to_out, fire, out_valid_r)
  `CAG_ASSERT_NEXT(a_bad_idx_zero, fire && !idx_ok, out_addr_r == '0)
  `CAG_ASSERT_NEXT(a_load_value, load_fire, out_addr_r == $past(s1_ld_r))

endmodule

// ----- src/cag_step.sv -----
// ----------------------------------------------------------------------------
// Circular address step unit
// Applies one operation to an address with modulo wrap against a buffer size.
// ----------------------------------------------------------------------------
module cag_step (
  input  logic [cag_pkg::OP_W-1:0]          operation,
  input  logic [cag_pkg::ADDR_W-1:0]        cur_addr,
  input  logic [cag_pkg::ADDR_W-1:0]        wrap_size,
  input  logic signed [cag_pkg::ADDR_W-1:0] index_value,
  input  logic [cag_pkg::ADDR_W-1:0]        load_value,
  output logic [cag_pkg::ADDR_W-1:0]        new_addr
);

  localparam int EW = cag_pkg::EXT_W;

  cag_pkg::op_t     op_e;
  logic [EW-1:0]    ar_x;
  logic [EW-1:0]    wr_x;
  logic [EW-1:0]    wr_p1;
  logic [EW-1:0]    mask;
  logic [EW-1:0]    ix_x;
  logic [EW-1:0]    nix_x;
  logic [EW-1:0]    sum_inc;
  logic [EW-1:0]    sum_dec;
  logic [EW-1:0]    sum_add;
  logic [EW-1:0]    sum_sub;
  logic [EW-1:0]    dar_add;
  logic [EW-1:0]    dar_sub;
  logic [EW-1:0]    res_x;

  // Pull back for an increasing step, push forward for a decreasing one
  function automatic logic [EW-1:0] fix_wrap(input logic [EW-1:0] s,
                                             input logic [EW-1:0] dar,
                                             input logic [EW-1:0] wr,
                                             input logic [EW-1:0] wr1,
                                             input logic          up);
    logic [EW-1:0] fwd;
    logic [EW-1:0] r;
    fwd = s + wr1;
    r   = s;
    if (up) begin
      if (dar > wr) r = s - wr1;
    end else begin
      if (((fwd ^ s) & dar) <= wr) r = fwd;
    end
    return r;
  endfunction

  assign op_e  = cag_pkg::op_t'(operation);
  assign ar_x  = {1'b0, cur_addr};
  assign wr_x  = {1'b0, wrap_size};
  assign wr_p1 = wr_x + EW'(1);
  assign mask  = {wrap_size | cag_pkg::ADDR_W'(1), 1'b0};
  assign ix_x  = {index_value[cag_pkg::ADDR_W-1], index_value};
  assign nix_x = ~ix_x;

  assign sum_inc = ar_x + EW'(1);
  assign sum_dec = ar_x + wr_x;
  assign sum_add = ar_x + ix_x;
  assign sum_sub = ar_x + nix_x + EW'(1);
  assign dar_add = (sum_add ^ ar_x ^ ix_x) & mask;
  assign dar_sub = (sum_sub ^ ar_x ^ nix_x) & mask;

  always_comb begin
    unique case (op_e)
      cag_pkg::OP_INC: begin
        res_x = ((sum_inc ^ ar_x) > mask) ? (sum_inc - wr_p1) : sum_inc;
      end
      cag_pkg::OP_DEC: begin
        res_x = (((sum_dec ^ ar_x) & mask) > wr_x) ? (sum_dec - wr_p1) : sum_dec;
      end
      cag_pkg::OP_ADD: begin
        res_x = fix_wrap(sum_add, dar_add, wr_x, wr_p1,
                         !index_value[cag_pkg::ADDR_W-1]);
      end
      cag_pkg::OP_SUB: begin
        // the most negative index counts as a decreasing step
        res_x = fix_wrap(sum_sub, dar_sub, wr_x, wr_p1,
                         nix_x < cag_pkg::NEG_LIMIT);
      end
      cag_pkg::OP_LOAD: begin
        res_x = {1'b0, load_value};
      end
      default: begin
        res_x = ar_x;
      end
    endcase
  end

  assign new_addr = res_x[cag_pkg::ADDR_W-1:0];

endmodule

// ----- sim/tb.sv -----
// ----------------------------------------------------------------------------
// Circular address generator testbench
// Drives address update requests and wrap-size writes, predicts every new
// address and compares each output transaction with the oldest prediction.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned RUN_LIMIT      = 400000;
  localparam int unsigned RX_HOLD_CYCLES = 60;
  localparam int unsigned SEGMENT_ITEMS  = 215;
  localparam int unsigned SETTLE_CYCLES  = 4;
  localparam logic [cag_pkg::OP_W-1:0] OP_FIRST_UNUSED = cag_pkg::OP_LOAD + 3'd1;
  localparam logic [cag_pkg::OP_W-1:0] OP_LAST_UNUSED  = '1;

  typedef struct packed {
    logic [cag_pkg::REG_IDX_W-1:0] result_register;
    cag_pkg::addr_t                new_address;
  } address_update_t;

  class address_tracker;
    cag_pkg::addr_t  addr_regs [cag_pkg::WRAP_REGS];
    cag_pkg::addr_t  wrap_sizes[cag_pkg::WRAP_REGS];
    address_update_t expected_updates[$];
    int unsigned     errors;

    function new();
      foreach (addr_regs[i]) begin
        addr_regs[i]  = '0;
        wrap_sizes[i] = cag_pkg::WRAP_RESET;
      end
      errors = 0;
    endfunction

    function void set_wrap(int unsigned idx, cag_pkg::addr_t size);
      wrap_sizes[idx] = size;
    endfunction

    // Modulo step at 32 bits, truncated on write-back
    function cag_pkg::addr_t next_address(logic [cag_pkg::OP_W-1:0] op,
                                          logic [cag_pkg::REG_IDX_W-1:0] r,
                                          logic [cag_pkg::ADDR_W-1:0] ix16,
                                          cag_pkg::addr_t ld);
      logic [31:0] ar, wr, m, nar, step, nstep, dar;
      logic        up;
      step = {{16{ix16[cag_pkg::ADDR_W-1]}}, ix16};
      ar   = {16'h0, addr_regs[r]};
      wr   = {16'h0, wrap_sizes[r]};
      m    = (wr | 32'd1) << 1;
      nar  = ar;
      dar  = '0;
      up   = 1'b1;
      case (op)
        cag_pkg::OP_INC: begin
          nar = ar + 32'd1;
          if ((nar ^ ar) > m) nar = nar - wr - 32'd1;
        end
        cag_pkg::OP_DEC: begin
          nar = ar + wr;
          if (((nar ^ ar) & m) > wr) nar = nar - wr - 32'd1;
        end
        cag_pkg::OP_ADD, cag_pkg::OP_SUB: begin
          nstep = (op == cag_pkg::OP_ADD) ? step : ~step;
          nar   = ar + nstep + ((op == cag_pkg::OP_SUB) ? 32'd1 : 32'd0);
          dar   = (nar ^ ar ^ nstep) & m;
          // an index of -32768 on subtract still counts as a decreasing step
          up    = (op == cag_pkg::OP_ADD) ? !step[31] : (nstep < 32'(cag_pkg::NEG_LIMIT));
          if (up) begin
            if (dar > wr) nar = nar - wr - 32'd1;
          end else begin
            if ((((nar + wr + 32'd1) ^ nar) & dar) <= wr) nar = nar + wr + 32'd1;
          end
        end
        cag_pkg::OP_LOAD: nar = {16'h0, ld};
        default: nar = ar;
      endcase
      addr_regs[r] = nar[cag_pkg::ADDR_W-1:0];
      return addr_regs[r];
    endfunction

    function void note_request(logic [cag_pkg::OP_W-1:0] op,
                               logic [cag_pkg::REG_IDX_W-1:0] r,
                               logic [cag_pkg::ADDR_W-1:0] ix16, cag_pkg::addr_t ld);
      address_update_t upd;
      upd.result_register = r;
      upd.new_address     = next_address(op, r, ix16, ld);
      expected_updates.push_back(upd);
    endfunction

    function void check_result(logic [cag_pkg::REG_IDX_W-1:0] r, cag_pkg::addr_t addr);
      address_update_t exp_upd;
      if (expected_updates.size() == 0) begin
        $display("%0t: unexpected transaction reg %0d addr %h", $time, r, addr);
        errors++;
        return;
      end
      exp_upd = expected_updates.pop_front();
      if (r !== exp_upd.result_register) begin
        $display("%0t: result_register expected %0d actual %0d",
                 $time, exp_upd.result_register, r);
        errors++;
      end
      if (addr !== exp_upd.new_address) begin
        $display("%0t: new_address expected %h actual %h",
                 $time, exp_upd.new_address, addr);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return expected_updates.size();
    endfunction
  endclass

  logic                          clk = 1'b0;
  logic                          rst_n;
  logic                          cfg_we;
  logic [cag_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [cag_pkg::ADDR_W-1:0]    cfg_wdata;

  int unsigned    tx_idle_pct;
  int unsigned    rx_idle_pct;
  bit             rx_hold_req;
  int unsigned    cycle_count;
  address_tracker tracker;

  cag_in_if  in_ch();
  cag_out_if out_ch();

  circular_address_generator dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < RUN_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("** circular_address_generator: FAILED **");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready)
      tracker.note_request(in_ch.operation, in_ch.register_index,
                           in_ch.index_value, in_ch.load_value);
    if (rst_n && out_ch.valid && out_ch.ready)
      tracker.check_result(out_ch.result_register, out_ch.new_address);
  end

  // Result side: random stalls, plus one long hold-off on request
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
      end
      out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  task automatic send_request(input logic [cag_pkg::OP_W-1:0] op,
                              input logic [cag_pkg::REG_IDX_W-1:0] r,
                              input logic [cag_pkg::ADDR_W-1:0] ix,
                              input cag_pkg::addr_t ld);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid       <= 1'b0;
      in_ch.index_value <= cag_pkg::ADDR_W'($urandom);
      in_ch.load_value  <= cag_pkg::ADDR_W'($urandom);
      @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.operation      <= op;
    in_ch.register_index <= r;
    in_ch.index_value    <= ix;
    in_ch.load_value     <= ld;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Stop offering and wait until every predicted address has come out
  task automatic drain();
    in_ch.valid <= 1'b0;
    // let the last accepted transaction reach the tracker first
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_wraps(
    input logic [cag_pkg::WRAP_REGS-1:0][cag_pkg::ADDR_W-1:0] sizes);
    for (int i = 0; i < cag_pkg::WRAP_REGS; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= cag_pkg::CFG_IDX_W'(i);
      cfg_wdata <= sizes[i];
      @(posedge clk);
      tracker.set_wrap(i, sizes[i]);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [cag_pkg::OP_W-1:0] OP_LOGIC_UNUSED();
    return cag_pkg::OP_W'($urandom_range(OP_LAST_UNUSED, OP_FIRST_UNUSED));
  endfunction

  function automatic logic [cag_pkg::OP_W-1:0] pick_op();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 25) return cag_pkg::OP_INC;
    if (roll < 50) return cag_pkg::OP_DEC;
    if (roll < 70) return cag_pkg::OP_ADD;
    if (roll < 90) return cag_pkg::OP_SUB;
    if (roll < 97) return cag_pkg::OP_LOAD;
    return OP_LOGIC_UNUSED();
  endfunction

  // Mostly steps within the buffer size, sometimes the extremes
  function automatic logic [cag_pkg::ADDR_W-1:0] pick_step(cag_pkg::addr_t wrap);
    int unsigned mag;
    case ($urandom_range(9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return cag_pkg::ADDR_W'($urandom);
      3: return ($urandom_range(1) != 0) ? 16'hFFFF : 16'h0001;
      default: begin
        mag = $urandom_range(wrap + 1);
        return ($urandom_range(1) != 0) ? cag_pkg::ADDR_W'(-mag) : cag_pkg::ADDR_W'(mag);
      end
    endcase
  endfunction

  function automatic cag_pkg::addr_t pick_wrap();
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      2: return cag_pkg::addr_t'((1 << $urandom_range(15, 1)) - 1);
      3: return cag_pkg::addr_t'($urandom_range(63));
      default: return cag_pkg::addr_t'($urandom);
    endcase
  endfunction

  task automatic run_segment(
    input int unsigned n_items,
    input logic [cag_pkg::WRAP_REGS-1:0][cag_pkg::ADDR_W-1:0] sizes,
    input bit hold_off);
    logic [cag_pkg::OP_W-1:0]      op;
    logic [cag_pkg::REG_IDX_W-1:0] r;
    cag_pkg::addr_t                ld;
    program_wraps(sizes);
    if (hold_off) rx_hold_req = 1'b1;
    repeat (n_items) begin
      op = pick_op();
      r  = cag_pkg::REG_IDX_W'($urandom_range(cag_pkg::WRAP_REGS - 1));
      ld = ($urandom_range(3) == 0) ? cag_pkg::addr_t'($urandom)
                                    : cag_pkg::addr_t'($urandom_range(sizes[r]));
      send_request(op, r, pick_step(sizes[r]), ld);
    end
    drain();
  endtask

  initial begin
    logic [cag_pkg::WRAP_REGS-1:0][cag_pkg::ADDR_W-1:0] sizes;
    tracker              = new();
    rst_n                = 1'b0;
    cfg_we               = 1'b0;
    cfg_index            = '0;
    cfg_wdata            = '0;
    in_ch.valid          = 1'b0;
    in_ch.operation      = cag_pkg::OP_INC;
    in_ch.register_index = '0;
    in_ch.index_value    = '0;
    in_ch.load_value     = '0;
    rx_hold_req          = 1'b0;
    tx_idle_pct          = 18;
    rx_idle_pct          = 45;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Default wrap sizes first, then one register each of a small, zero,
    // full and half-range buffer
    send_request(cag_pkg::OP_DEC, 2'd0, '0, '0);
    send_request(cag_pkg::OP_INC, 2'd0, '0, '0);
    drain();
    sizes = {16'h8000, 16'hFFFF, 16'h0000, 16'h000F};
    program_wraps(sizes);
    send_request(cag_pkg::OP_DEC, 2'd0, '0, '0);
    send_request(cag_pkg::OP_LOAD, 2'd0, '0, 16'h000F);
    send_request(cag_pkg::OP_INC, 2'd0, '0, '0);
    send_request(cag_pkg::OP_INC, 2'd1, '0, '0);
    send_request(cag_pkg::OP_DEC, 2'd1, '0, '0);
    send_request(cag_pkg::OP_ADD, 2'd1, 16'h7FFF, '0);
    send_request(cag_pkg::OP_LOAD, 2'd2, '0, 16'hFFFF);
    send_request(cag_pkg::OP_INC, 2'd2, '0, '0);
    send_request(cag_pkg::OP_DEC, 2'd2, '0, '0);
    send_request(cag_pkg::OP_ADD, 2'd2, 16'h7FFF, '0);
    send_request(cag_pkg::OP_ADD, 2'd2, 16'h8000, '0);
    send_request(cag_pkg::OP_SUB, 2'd2, 16'h8000, '0);
    send_request(cag_pkg::OP_SUB, 2'd2, 16'h7FFF, '0);
    send_request(cag_pkg::OP_SUB, 2'd2, 16'hFFFF, '0);
    send_request(cag_pkg::OP_ADD, 2'd2, 16'hFFFF, '0);
    send_request(cag_pkg::OP_LOAD, 2'd3, '0, 16'h5555);
    send_request(cag_pkg::OP_ADD, 2'd3, 16'h5555, '0);
    send_request(cag_pkg::OP_LOAD, 2'd3, '0, 16'hAAAA);
    send_request(cag_pkg::OP_SUB, 2'd3, 16'hAAAA, '0);
    send_request(cag_pkg::OP_SUB, 2'd3, 16'h8000, '0);
    for (int k = OP_FIRST_UNUSED; k <= OP_LAST_UNUSED; k++)
      send_request(cag_pkg::OP_W'(k), cag_pkg::REG_IDX_W'(k), 16'h1234, 16'h4321);
    drain();

    for (int p = 0; p < 3; p++) begin
      tx_idle_pct = (p == 0) ? 18 : (p == 1) ? 45 : 0;
      rx_idle_pct = (p == 0) ? 45 : (p == 1) ? 18 : 0;
      for (int s = 0; s < 2; s++) begin
        if (p == 0 && s == 0) begin
          sizes = {16'h003F, 16'h7FFF, 16'h0000, 16'hFFFF};
        end else begin
          for (int i = 0; i < cag_pkg::WRAP_REGS; i++) sizes[i] = pick_wrap();
        end
        run_segment(SEGMENT_ITEMS, sizes, s == 0);
      end
    end

    if (tracker.errors == 0) begin
      $display("** circular_address_generator: PASSED **");
    end else begin
      $display("** circular_address_generator: FAILED **");
    end
    $finish;
  end

endmodule
